FILE: design/dhrs_pkg.sv
// ----------------------------------------------------------------------------
// dhrs_pkg
// shared constants for the disk head request scheduler
// ----------------------------------------------------------------------------
`default_nettype none
package dhrs_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int TRACK_BITS = 10;
	localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_BITS = 16;

	localparam logic [2:0] POL_FIFO  = 3'd0;
	localparam logic [2:0] POL_SSTF  = 3'd1;
	localparam logic [2:0] POL_LOOK  = 3'd2;
	localparam logic [2:0] POL_CLOOK = 3'd3;
	localparam logic [2:0] POL_FLOOK = 3'd4;

	localparam logic [1:0] EV_ISSUE    = 2'd0;
	localparam logic [1:0] EV_COMPLETE = 2'd1;
	localparam logic [1:0] EV_TICK_END = 2'd2;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;
endpackage
`default_nettype wire

FILE: design/disk_head_request_scheduler.sv
// ----------------------------------------------------------------------------
// disk_head_request_scheduler
// tick-driven disk request queue with fifo, sstf, look, clook and flook pick
// ----------------------------------------------------------------------------
// Each input transfer is one tick and may carry one request. The queue lives
// in a 16-entry memory kept compacted in arrival order; selection scans it
// one entry per cycle through the registered read port, and removal of an
// entry shifts later entries down one at a time (read, then write). A tick
// with no issue goes through accept, completion check, select, move, tick
// end and a wait for the tick-end transfer. Each issue adds one to four
// scans of the queue, a fetch of the entry and the issue send, a compaction
// and a new completion check and select; output stalls lengthen a tick. No
// clearing pass is needed after reset. The next tick is accepted only once
// the tick-end event has been transferred out.
// ----------------------------------------------------------------------------
`default_nettype none
module disk_head_request_scheduler (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [2:0]                       cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             arrival_valid,
	input  wire logic [dhrs_pkg::TRACK_BITS-1:0]  arrival_track,
	input  wire logic [15:0]                      arrival_tag,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [1:0]                            event_kind,
	output logic [15:0]                           event_tag,
	output logic [dhrs_pkg::TRACK_BITS-1:0]       event_track,
	output logic [dhrs_pkg::TRACK_BITS-1:0]       head_position,
	output logic [31:0]                           event_time,
	output logic                                  busy_res,
	output logic [4:0]                            pending_count,
	output logic [31:0]                           total_movement,
	output logic                                  arrival_dropped,
	output logic                                  last_event
);
	import dhrs_pkg::*;

	localparam int EW = 1 + TRACK_BITS + TAG_BITS;
	localparam int DW = TRACK_BITS + 1;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CMPL  = 4'd1;
	localparam logic [3:0] S_SEL   = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_SDONE = 4'd4;
	localparam logic [3:0] S_TAKE  = 4'd5;
	localparam logic [3:0] S_TAKE2 = 4'd6;
	localparam logic [3:0] S_SHRD  = 4'd7;
	localparam logic [3:0] S_SHWR  = 4'd8;
	localparam logic [3:0] S_MOVE  = 4'd9;
	localparam logic [3:0] S_END   = 4'd10;
	localparam logic [3:0] S_WAIT  = 4'd11;

	// scan modes
	localparam logic [2:0] M_SSTF = 3'd0;
	localparam logic [2:0] M_UP   = 3'd1;
	localparam logic [2:0] M_DOWN = 3'd2;
	localparam logic [2:0] M_MIN  = 3'd3;
	localparam logic [2:0] M_ANY  = 3'd4;

	// look scan steps
	localparam logic [1:0] L_FIRST = 2'd0;
	localparam logic [1:0] L_DOWN  = 2'd1;
	localparam logic [1:0] L_LAST  = 2'd2;

	// queue memory: {list, track, tag}
	logic [EW-1:0] mem [QUEUE_DEPTH];
	logic [EW-1:0] rd_s1;
	logic [IDX_BITS-1:0] raddr;
	logic          re;
	logic          we;
	logic [IDX_BITS-1:0] waddr;
	logic [EW-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_s1 <= mem[raddr];
	end

	logic [3:0]            state_q;
	logic [2:0]            policy_q;
	logic [TRACK_BITS-1:0] head_q;
	logic [1:0]            dir_q;
	logic                  act_q;
	logic [TRACK_BITS-1:0] act_trk_q;
	logic [15:0]           act_tag_q;
	logic                  serv_q;
	logic [31:0]           time_q;
	logic [31:0]           move_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  drop_q;

	logic [2:0]            mode_q;
	logic [1:0]            lstep_q;
	logic                  filt_q;
	logic [CNT_BITS-1:0]   scan_q;
	logic                  scan_rd_q;
	logic [IDX_BITS-1:0]   scan_idx_q;
	logic                  found_q;
	logic [IDX_BITS-1:0]   best_q;
	logic [DW-1:0]         bestd_q;
	logic [TRACK_BITS-1:0] bestt_q;
	logic [1:0]            newdir_q;
	logic [CNT_BITS-1:0]   sh_q;

	// per-entry compare on the registered read data
	logic                  e_list;
	logic [TRACK_BITS-1:0] e_trk;
	logic                  e_ok;
	logic [DW-1:0]         e_dist;
	logic                  e_better;

	assign e_list = rd_s1[EW-1];
	assign e_trk  = rd_s1[TAG_BITS +: TRACK_BITS];

	always_comb begin
		e_ok = !filt_q || (e_list == serv_q);
		e_dist = '0;
		e_better = 1'b0;
		unique case (mode_q)
			M_SSTF: begin
				e_dist = (e_trk > head_q) ? {1'b0, e_trk - head_q} : {1'b0, head_q - e_trk};
				e_better = !found_q || e_dist < bestd_q;
			end
			M_UP: begin
				e_ok = e_ok && e_trk >= head_q;
				e_dist = {1'b0, e_trk - head_q};
				e_better = !found_q || e_dist < bestd_q;
			end
			M_DOWN: begin
				e_ok = e_ok && e_trk <= head_q;
				e_dist = {1'b0, head_q - e_trk};
				e_better = !found_q || e_dist < bestd_q;
			end
			M_MIN: begin
				e_dist = {1'b0, e_trk};
				e_better = !found_q || e_dist < bestd_q;
			end
			M_ANY: begin
				e_better = !found_q;
			end
			default: begin
				e_ok = 1'b0;
			end
		endcase
	end

	// output register
	logic ev_load;
	logic [1:0] ev_kind_d;
	logic [15:0] ev_tag_d;
	logic [TRACK_BITS-1:0] ev_trk_d;
	logic ev_busy_d;
	logic [CNT_BITS-1:0] ev_cnt_d;

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (ev_load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ev_load) begin
			event_kind      <= ev_kind_d;
			event_tag       <= ev_tag_d;
			event_track     <= ev_trk_d;
			head_position   <= head_q;
			event_time      <= time_q;
			busy_res        <= ev_busy_d;
			pending_count   <= 5'(ev_cnt_d);
			total_movement  <= move_q;
			arrival_dropped <= (ev_kind_d == EV_TICK_END) && drop_q;
			last_event      <= (ev_kind_d == EV_TICK_END);
		end
	end

	// the output register is free when empty or being drained
	logic ev_free;
	assign ev_free = !out_valid || !out_stall;

	// pending count after the issued entry leaves the queue
	logic [CNT_BITS-1:0] cnt_less;
	assign cnt_less = cnt_q - 1'b1;

	// combinational control
	always_comb begin
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		ev_load = 1'b0;
		ev_kind_d = EV_TICK_END;
		ev_tag_d = '0;
		ev_trk_d = '0;
		ev_busy_d = act_q;
		ev_cnt_d = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && arrival_valid && cnt_q < CNT_BITS'(QUEUE_DEPTH)) begin
					we = 1'b1;
					waddr = cnt_q[IDX_BITS-1:0];
					wdata = {~serv_q, arrival_track, arrival_tag};
				end
			end
			S_CMPL: begin
				if (act_q && act_trk_q == head_q && ev_free) begin
					ev_load = 1'b1;
					ev_kind_d = EV_COMPLETE;
					ev_tag_d = act_tag_q;
					ev_trk_d = act_trk_q;
					ev_busy_d = 1'b0;
				end
			end
			S_SCAN: begin
				re = scan_q < CNT_BITS'(QUEUE_DEPTH) && scan_q < cnt_q;
				raddr = scan_q[IDX_BITS-1:0];
			end
			S_TAKE: begin
				re = 1'b1;
				raddr = best_q;
			end
			S_TAKE2: begin
				if (ev_free) begin
					ev_load = 1'b1;
					ev_kind_d = EV_ISSUE;
					ev_tag_d = rd_s1[TAG_BITS-1:0];
					ev_trk_d = e_trk;
					ev_busy_d = 1'b1;
					// the issued entry no longer counts as waiting
					ev_cnt_d = cnt_less;
				end
			end
			S_SHRD: begin
				re = 1'b1;
				raddr = IDX_BITS'(sh_q + 1'b1);
			end
			S_SHWR: begin
				we = 1'b1;
				waddr = sh_q[IDX_BITS-1:0];
				wdata = rd_s1;
			end
			S_END: begin
				if (ev_free) begin
					ev_load = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			policy_q   <= POL_FIFO;
			head_q     <= '0;
			dir_q      <= DIR_NONE;
			act_q      <= 1'b0;
			act_trk_q  <= '0;
			act_tag_q  <= '0;
			serv_q     <= 1'b0;
			time_q     <= '0;
			move_q     <= '0;
			cnt_q      <= '0;
			drop_q     <= 1'b0;
			mode_q     <= M_ANY;
			lstep_q    <= L_FIRST;
			filt_q     <= 1'b0;
			scan_q     <= '0;
			scan_rd_q  <= 1'b0;
			scan_idx_q <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			bestd_q    <= '0;
			bestt_q    <= '0;
			newdir_q   <= DIR_NONE;
			sh_q       <= '0;
		end else begin
			if (cfg_we)
				policy_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						drop_q <= arrival_valid && cnt_q == CNT_BITS'(QUEUE_DEPTH);
						if (arrival_valid && cnt_q < CNT_BITS'(QUEUE_DEPTH))
							cnt_q <= cnt_q + 1'b1;
						state_q <= S_CMPL;
					end
				end
				S_CMPL: begin
					if (act_q && act_trk_q == head_q) begin
						if (ev_free) begin
							act_q <= 1'b0;
							state_q <= S_SEL;
						end
					end else begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					// start a scan for the current policy, unless a request is active or the queue is empty
					scan_q <= '0;
					scan_rd_q <= 1'b0;
					found_q <= 1'b0;
					lstep_q <= L_FIRST;
					filt_q <= 1'b0;
					if (act_q || cnt_q == '0) begin
						state_q <= S_MOVE;
					end else begin
						state_q <= S_SCAN;
						priority case (policy_q)
							POL_SSTF:  mode_q <= M_SSTF;
							POL_LOOK:  mode_q <= (dir_q == DIR_DOWN) ? M_DOWN : M_UP;
							POL_CLOOK: mode_q <= M_UP;
							POL_FLOOK: begin
								// first pass checks whether the serving list is empty
								mode_q <= M_ANY;
								filt_q <= 1'b1;
							end
							default:   mode_q <= M_ANY;
						endcase
						if (policy_q == POL_LOOK && dir_q == DIR_DOWN)
							lstep_q <= L_DOWN;
					end
				end
				S_SCAN: begin
					scan_rd_q <= re;
					scan_idx_q <= scan_q[IDX_BITS-1:0];
					if (scan_rd_q && e_ok && e_better) begin
						found_q <= 1'b1;
						best_q <= scan_idx_q;
						bestd_q <= e_dist;
						bestt_q <= e_trk;
					end
					if (re)
						scan_q <= scan_q + 1'b1;
					else if (!scan_rd_q)
						state_q <= S_SDONE;
				end
				S_SDONE: begin
					scan_q <= '0;
					scan_rd_q <= 1'b0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
					priority if (policy_q == POL_SSTF) begin
						newdir_q <= (bestt_q > head_q) ? DIR_UP : DIR_DOWN;
						state_q <= S_TAKE;
					end else if (policy_q == POL_CLOOK) begin
						if (found_q && mode_q == M_UP) begin
							newdir_q <= DIR_UP;
							state_q <= S_TAKE;
						end else if (mode_q == M_UP) begin
							mode_q <= M_MIN;
						end else begin
							newdir_q <= DIR_DOWN;
							state_q <= S_TAKE;
						end
					end else if (policy_q == POL_LOOK
						|| (policy_q == POL_FLOOK && mode_q != M_ANY)) begin
						if (found_q) begin
							newdir_q <= (lstep_q == L_DOWN) ? DIR_DOWN : DIR_UP;
							state_q <= S_TAKE;
						end else if (lstep_q == L_FIRST) begin
							lstep_q <= L_DOWN;
							mode_q <= M_DOWN;
						end else if (lstep_q == L_DOWN) begin
							lstep_q <= L_LAST;
							mode_q <= M_UP;
						end else begin
							// nothing eligible: direction still turns up
							dir_q <= DIR_UP;
							state_q <= S_MOVE;
						end
					end else if (policy_q == POL_FLOOK) begin
						// list emptiness check done
						if (!found_q)
							serv_q <= ~serv_q;
						if (dir_q == DIR_DOWN) begin
							lstep_q <= L_DOWN;
							mode_q <= M_DOWN;
						end else begin
							lstep_q <= L_FIRST;
							mode_q <= M_UP;
						end
					end else begin
						// fifo and unused codes: entry 0
						best_q <= '0;
						newdir_q <= (bestt_q > head_q) ? DIR_UP : DIR_DOWN;
						state_q <= S_TAKE;
					end
				end
				S_TAKE: begin
					state_q <= S_TAKE2;
				end
				S_TAKE2: begin
					if (ev_free) begin
						act_q <= 1'b1;
						act_trk_q <= e_trk;
						act_tag_q <= rd_s1[TAG_BITS-1:0];
						dir_q <= newdir_q;
						cnt_q <= cnt_less;
						sh_q <= CNT_BITS'(best_q);
						state_q <= S_SHRD;
					end
				end
				S_SHRD: begin
					// cnt_q is already reduced: move entries best+1..cnt down into best..cnt-1
					if (sh_q >= cnt_q)
						state_q <= S_CMPL;
					else
						state_q <= S_SHWR;
				end
				S_SHWR: begin
					sh_q <= sh_q + 1'b1;
					state_q <= S_SHRD;
				end
				S_MOVE: begin
					if (act_q && dir_q == DIR_UP) begin
						head_q <= head_q + 1'b1;
						move_q <= move_q + 1'b1;
					end else if (act_q && dir_q == DIR_DOWN) begin
						head_q <= head_q - 1'b1;
						move_q <= move_q + 1'b1;
					end
					state_q <= S_END;
				end
				S_END: begin
					if (ev_free) begin
						time_q <= time_q + 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (ev_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("pending count out of range");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAKE2 && ev_free) |=> act_q)
		else $error("issue did not set active request");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_event) |-> event_kind == EV_TICK_END)
		else $error("last flag on a non tick-end event");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_IDLE || state_q == S_SHWR))
		else $error("queue written outside arrival or compaction");
`endif
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the disk head request scheduler
// ----------------------------------------------------------------------------
// Ticks are driven into the block as input transfers. Each accepted tick goes
// through a scoreboard that keeps its own copy of the queue, head, direction
// and policy, and predicts the issue, complete and tick-end events. Output
// transfers are compared field by field against the oldest prediction. Phases
// cycle through every policy, including unused codes 5 and 7, under varying
// idle and stall patterns. Two phases also add a long output hold-off that
// fills the queue and backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dhrs_pkg::*;

	localparam int RUN_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 700;

	typedef struct {
		logic [1:0]            kind;
		logic [15:0]           tag;
		logic [TRACK_BITS-1:0] trk;
		logic [TRACK_BITS-1:0] head;
		logic [31:0]           tm;
		logic                  busy;
		logic [4:0]            pend;
		logic [31:0]           moved;
		logic                  dropped;
		logic                  last;
	} sched_event_t;

	// scheduler shadow model plus the store of predicted events
	class sched_scoreboard;
		logic [TRACK_BITS-1:0] q_trk[QUEUE_DEPTH];
		logic [15:0]           q_tag[QUEUE_DEPTH];
		bit                    q_vld[QUEUE_DEPTH];
		bit                    q_lst[QUEUE_DEPTH];
		logic [TRACK_BITS-1:0] head;
		logic [1:0]            dir;
		bit                    act_v;
		logic [TRACK_BITS-1:0] act_trk;
		logic [15:0]           act_tag;
		bit                    serve;
		logic [31:0]           ticks;
		logic [31:0]           moved;
		logic [2:0]            pol;
		sched_event_t          predicted[$];
		int                    errors;

		function new();
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				q_vld[k] = 0;
				q_trk[k] = '0;
				q_tag[k] = '0;
				q_lst[k] = 0;
			end
			head = '0;
			dir = DIR_NONE;
			act_v = 0;
			act_trk = '0;
			act_tag = '0;
			serve = 0;
			ticks = '0;
			moved = '0;
			pol = POL_FIFO;
			errors = 0;
		endfunction

		function int n_waiting();
			int n;
			n = 0;
			for (int k = 0; k < QUEUE_DEPTH; k++)
				if (q_vld[k]) n++;
			return n;
		endfunction

		function void push_event(logic [1:0] kind, logic [15:0] tag,
				logic [TRACK_BITS-1:0] trk, bit dropped, bit last);
			sched_event_t e;
			e.kind = kind;
			e.tag = tag;
			e.trk = trk;
			e.head = head;
			e.tm = ticks;
			e.busy = act_v;
			e.pend = 5'(n_waiting());
			e.moved = moved;
			e.dropped = dropped;
			e.last = last;
			predicted.insert(predicted.size(), e);
		endfunction

		function bit usable(int k, bit filt);
			return q_vld[k] && (!filt || q_lst[k] == serve);
		endfunction

		// closest entry at or above (up) or at or below the head; oldest wins ties
		function int nearest(bit up, bit filt);
			int best;
			logic [TRACK_BITS-1:0] bd, d;
			best = -1;
			bd = '0;
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				if (!usable(k, filt)) continue;
				if (up ? (q_trk[k] < head) : (q_trk[k] > head)) continue;
				d = up ? q_trk[k] - head : head - q_trk[k];
				if (best < 0 || d < bd) begin
					best = k;
					bd = d;
				end
			end
			return best;
		endfunction

		function int look_sweep(bit filt);
			int k;
			if (dir != DIR_DOWN) begin
				k = nearest(1, filt);
				if (k >= 0) begin
					dir = DIR_UP;
					return k;
				end
			end
			k = nearest(0, filt);
			if (k >= 0) begin
				dir = DIR_DOWN;
				return k;
			end
			k = nearest(1, filt);
			dir = DIR_UP;
			return k;
		endfunction

		function int choose();
			int k;
			bit any;
			logic [TRACK_BITS-1:0] bd, d;
			k = -1;
			bd = '0;
			any = 0;
			case (pol)
				POL_SSTF: begin
					for (int j = 0; j < QUEUE_DEPTH; j++) begin
						if (!q_vld[j]) continue;
						d = q_trk[j] > head ? q_trk[j] - head : head - q_trk[j];
						if (k < 0 || d < bd) begin
							k = j;
							bd = d;
						end
					end
					if (k >= 0) dir = (q_trk[k] > head) ? DIR_UP : DIR_DOWN;
				end
				POL_LOOK: k = look_sweep(0);
				POL_CLOOK: begin
					k = nearest(1, 0);
					if (k >= 0) begin
						dir = DIR_UP;
					end else begin
						for (int j = 0; j < QUEUE_DEPTH; j++)
							if (q_vld[j] && (k < 0 || q_trk[j] < q_trk[k])) k = j;
						dir = DIR_DOWN;
					end
				end
				POL_FLOOK: begin
					for (int j = 0; j < QUEUE_DEPTH; j++)
						if (usable(j, 1)) any = 1;
					if (!any) serve = !serve;
					k = look_sweep(1);
				end
				default: begin
					if (q_vld[0]) begin
						k = 0;
						dir = (q_trk[0] > head) ? DIR_UP : DIR_DOWN;
					end
				end
			endcase
			return k;
		endfunction

		function void take_out(int k);
			for (int j = k; j + 1 < QUEUE_DEPTH; j++) begin
				q_trk[j] = q_trk[j + 1];
				q_tag[j] = q_tag[j + 1];
				q_lst[j] = q_lst[j + 1];
				q_vld[j] = q_vld[j + 1];
			end
			q_vld[QUEUE_DEPTH - 1] = 0;
		endfunction

		// one accepted tick: predict all of its events
		function void note_tick(bit av, logic [TRACK_BITS-1:0] trk, logic [15:0] tag);
			int c, k;
			bit dropped;
			dropped = 0;
			if (av) begin
				c = n_waiting();
				if (c < QUEUE_DEPTH) begin
					q_trk[c] = trk;
					q_tag[c] = tag;
					q_lst[c] = !serve;
					q_vld[c] = 1;
				end else begin
					dropped = 1;
				end
			end
			if (act_v && act_trk == head) begin
				act_v = 0;
				push_event(EV_COMPLETE, act_tag, act_trk, 0, 0);
			end
			while (!act_v && n_waiting() > 0) begin
				k = choose();
				if (k < 0) break;
				act_trk = q_trk[k];
				act_tag = q_tag[k];
				act_v = 1;
				take_out(k);
				push_event(EV_ISSUE, act_tag, act_trk, 0, 0);
				if (act_trk == head) begin
					act_v = 0;
					push_event(EV_COMPLETE, act_tag, act_trk, 0, 0);
				end
			end
			if (act_v && dir == DIR_UP) begin
				head = head + 1'b1;
				moved = moved + 1;
			end else if (act_v && dir == DIR_DOWN) begin
				head = head - 1'b1;
				moved = moved + 1;
			end
			push_event(EV_TICK_END, '0, '0, dropped, 1);
			ticks = ticks + 1;
		endfunction

		function bit same(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
					want, got);
				return 0;
			end
			return 1;
		endfunction

		function void check_event(sched_event_t a);
			sched_event_t e;
			bit ok;
			if (predicted.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual kind %0d tag %0h",
					$realtime, a.kind, a.tag);
				errors++;
				return;
			end
			e = predicted[0];
			predicted.delete(0);
			ok = same("event_kind", e.kind, a.kind);
			ok &= same("event_tag", e.tag, a.tag);
			ok &= same("event_track", e.trk, a.trk);
			ok &= same("head_position", e.head, a.head);
			ok &= same("event_time", e.tm, a.tm);
			ok &= same("busy_res", e.busy, a.busy);
			ok &= same("pending_count", e.pend, a.pend);
			ok &= same("total_movement", e.moved, a.moved);
			ok &= same("arrival_dropped", e.dropped, a.dropped);
			ok &= same("last_event", e.last, a.last);
			if (!ok) errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_stall;
	logic arrival_valid = 0;
	logic [TRACK_BITS-1:0] arrival_track = '0;
	logic [15:0] arrival_tag = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] event_kind;
	logic [15:0] event_tag;
	logic [TRACK_BITS-1:0] event_track;
	logic [TRACK_BITS-1:0] head_position;
	logic [31:0] event_time;
	logic busy_res;
	logic [4:0] pending_count;
	logic [31:0] total_movement;
	logic arrival_dropped;
	logic last_event;

	sched_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;

	disk_head_request_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.arrival_valid(arrival_valid),
		.arrival_track(arrival_track),
		.arrival_tag(arrival_tag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.event_tag(event_tag),
		.event_track(event_track),
		.head_position(head_position),
		.event_time(event_time),
		.busy_res(busy_res),
		.pending_count(pending_count),
		.total_movement(total_movement),
		.arrival_dropped(arrival_dropped),
		.last_event(last_event)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// both channels are observed at the rising edge, before the block updates
	always @(posedge clk) begin
		sched_event_t a;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_tick(arrival_valid, arrival_track, arrival_tag);
			if (out_valid && !out_stall) begin
				a.kind = event_kind;
				a.tag = event_tag;
				a.trk = event_track;
				a.head = head_position;
				a.tm = event_time;
				a.busy = busy_res;
				a.pend = pending_count;
				a.moved = total_movement;
				a.dropped = arrival_dropped;
				a.last = last_event;
				sb.check_event(a);
			end
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	// one tick transfer, with random idle cycles in front of it
	task automatic send_tick(bit av, logic [TRACK_BITS-1:0] trk, logic [15:0] tag);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		arrival_valid = av;
		arrival_track = trk;
		arrival_tag = tag;
		do @(posedge clk); while (in_stall);
	endtask

	// sender pauses until every predicted event is out and the block has settled
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.predicted.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_policy(logic [2:0] p);
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = p;
		@(negedge clk);
		cfg_we = 0;
		sb.pol = p;
	endtask

	// track near the head most of the time, so requests actually complete
	function automatic logic [TRACK_BITS-1:0] pick_track();
		int r, t;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 16) return '1;
		if (r < 28) return TRACK_BITS'($urandom);
		t = int'(sb.head) + $urandom_range(48) - 24;
		if (t < 0) t = 0;
		if (t > (1 << TRACK_BITS) - 1) t = (1 << TRACK_BITS) - 1;
		return TRACK_BITS'(t);
	endfunction

	task automatic random_ticks(int n, int arrive_pct);
		repeat (n)
			send_tick($urandom_range(99) < arrive_pct, pick_track(), 16'($urandom));
	endtask

	logic [2:0] phase_pol[8] = '{POL_SSTF, POL_LOOK, POL_CLOOK, POL_FLOOK, 3'd7,
		POL_FIFO, POL_FLOOK, 3'd5};
	int idle_mix[4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{21, 21}};

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: fifo with extremes, a hit under the head, idle ticks
		set_policy(POL_FIFO);
		send_tick(1, '0, 16'h0000);
		send_tick(0, '1, 16'hffff);
		send_tick(1, 10'd3, 16'hffff);
		send_tick(1, 10'd1, 16'h1234);
		send_tick(1, 10'd2, 16'h5555);
		send_tick(0, 10'h2aa, 16'haaaa);
		send_tick(1, 10'd2, 16'h0001);
		repeat (6) send_tick(0, '0, '0);
		send_tick(1, 10'h155, 16'h8000);
		send_tick(1, 10'h2aa, 16'h7fff);
		send_tick(1, '1, 16'hfffe);
		repeat (4) send_tick(0, '0, '0);
		drain();

		// policy change with requests still waiting in the queue
		set_policy(POL_SSTF);
		send_tick(1, 10'd4, 16'h0abc);
		send_tick(1, 10'd4, 16'h0abd);
		drain();

		// random phases over all policies and idle mixes
		for (int ph = 0; ph < 8; ph++) begin
			set_policy(phase_pol[ph]);
			send_idle_pct = idle_mix[ph % 4][0];
			recv_stall_pct = idle_mix[ph % 4][1];
			random_ticks(24, 60);
			if (ph == 2 || ph == 6) begin
				// long output hold-off with arrivals every tick fills the queue
				hold_reqs++;
				random_ticks(24, 100);
			end
			random_ticks(26, 55);
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (sb.errors == 0 && sb.predicted.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
design/dhrs_pkg.sv
design/disk_head_request_scheduler.sv
sim/tb_top.sv
